FILE: sv/rll_pkg.sv
// Shared types and constants for the relocating linking loader.
package rll_pkg;

  localparam int unsigned SymbolEntriesDef = 64;
  localparam int unsigned MaxSectionsDef   = 16;
  localparam int unsigned MemAddrBitsDef   = 20;

  localparam int unsigned AddrW    = 20;
  localparam int unsigned NameW    = 48;
  localparam int unsigned WideAddrW = 25;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 32;

  localparam logic [3:0] HalfBytesShort = 4'd5;
  localparam logic [3:0] HalfBytesLong  = 4'd6;

  typedef enum logic [2:0] {
    OP_HDR1   = 3'd0,
    OP_DEFINE = 3'd1,
    OP_HDR2   = 3'd2,
    OP_TEXT   = 3'd3,
    OP_MODIFY = 3'd4,
    OP_READ   = 3'd5,
    OP_LOOKUP = 3'd6,
    OP_NONE   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEC,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_ENTER,
    S_MOD_RD,
    S_MOD_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e           status;
    logic              found;
    logic [AddrW-1:0]  symbol_value;
    logic [7:0]        read_data;
  } result_t;

  typedef struct packed {
    logic [NameW-1:0] name;
    logic [AddrW-1:0] value;
  } sym_entry_t;

endpackage

FILE: sv/rll_sym_ram.sv
// Symbol table storage: one write port, one registered read port.
module rll_sym_ram #(
  parameter int unsigned ENTRIES = rll_pkg::SymbolEntriesDef,
  parameter int unsigned IW      = $clog2(ENTRIES)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [IW-1:0]           waddr_i,
  input  rll_pkg::sym_entry_t     wdata_i,
  input  logic [IW-1:0]           raddr_i,
  output rll_pkg::sym_entry_t     rdata_o
);
  import rll_pkg::*;

  sym_entry_t mem_q [ENTRIES];
  sym_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/relocating_linking_loader.sv
// Top level of the relocating linking loader.
// Takes one pre-parsed object record per transfer and returns one result per record.
// Symbol searches read the symbol table RAM one entry at a time and stop at a match.
// A define, a pass-1 header, a lookup or a modify first searches the table when it holds
// symbols; a modify then reads the three bytes and writes them back. Text records write
// one byte and read records read one; a full section table, a bad modify length or an
// extra pass-2 header goes straight to the result.
// The next record is taken while a result waits in the output register; a record whose
// result is ready holds the input until that register frees up. Memory and tables have no
// reset value; reading a byte never written returns an undefined value.
module relocating_linking_loader #(
  parameter int unsigned SYMBOL_ENTRIES = rll_pkg::SymbolEntriesDef,
  parameter int unsigned MAX_SECTIONS   = rll_pkg::MaxSectionsDef,
  parameter int unsigned MEM_ADDR_BITS  = rll_pkg::MemAddrBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rll_pkg::AddrW-1:0]     cfg_wdata_i,     // load_origin
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // operation, name, address, length, data, half_bytes, subtract
  input  logic [rll_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // read_data, symbol_value, found, status, zero fill
  output logic [rll_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import rll_pkg::*;

  localparam int unsigned IW = $clog2(SYMBOL_ENTRIES);
  localparam int unsigned CW = $clog2(SYMBOL_ENTRIES + 1);
  localparam int unsigned SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int unsigned DW = $clog2(MAX_SECTIONS + 1);

  // input fields
  op_e              in_op;
  logic [NameW-1:0] in_name;
  logic [AddrW-1:0] in_addr;
  logic [AddrW-1:0] in_len;
  logic [7:0]       in_data;
  logic [3:0]       in_hb;
  logic             in_sub;
  logic             accept;

  assign in_op   = op_e'(s_axis_tdata_i[2:0]);
  assign in_name = s_axis_tdata_i[50:3];
  assign in_addr = s_axis_tdata_i[70:51];
  assign in_len  = s_axis_tdata_i[90:71];
  assign in_data = s_axis_tdata_i[98:91];
  assign in_hb   = s_axis_tdata_i[102:99];
  assign in_sub  = s_axis_tdata_i[103];

  state_e state_q, state_d;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  logic [AddrW-1:0] origin_q;
  logic [CW-1:0]    count_q, count_d;
  logic [DW-1:0]    dsc_q, dsc_d;
  logic [DW-1:0]    lsi_q, lsi_d;
  logic [AddrW-1:0] nfa_q, nfa_d;
  logic [AddrW-1:0] cds_q, cds_d;
  logic [AddrW-1:0] cls_q, cls_d;

  op_e              op_q, op_d;
  logic [NameW-1:0] name_q, name_d;
  logic [AddrW-1:0] val_q, val_d;
  logic [AddrW-1:0] ma_q, ma_d;
  logic             hb5_q, hb5_d;
  logic             sub_q, sub_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic             found_q, found_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [7:0]       b_q [3];
  logic [7:0]       b_d [3];
  result_t          res_q, res_d;
  result_t          out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             search_end;
  logic             load_out;

  // symbol table
  logic       sym_we;
  logic [IW-1:0] sym_waddr;
  sym_entry_t sym_wdata;
  sym_entry_t sym_rdata;

  rll_sym_ram #(
    .ENTRIES (SYMBOL_ENTRIES),
    .IW      (IW)
  ) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (sym_we),
    .waddr_i (sym_waddr),
    .wdata_i (sym_wdata),
    .raddr_i (idx_q),
    .rdata_o (sym_rdata)
  );

  // section start table
  logic [AddrW-1:0] sec_mem_q [MAX_SECTIONS];
  logic [AddrW-1:0] sec_rdata_q;
  logic             sec_we;
  logic [AddrW-1:0] sec_wdata;

  always_ff @(posedge clk_i) begin
    if (sec_we) begin
      sec_mem_q[dsc_q[SW-1:0]] <= sec_wdata;
    end
    sec_rdata_q <= sec_mem_q[lsi_q[SW-1:0]];
  end

  // byte memory
  logic [7:0]               mem_q [2**MEM_ADDR_BITS];
  logic [7:0]               mem_rdata_q;
  logic                     mem_we;
  logic [MEM_ADDR_BITS-1:0] mem_raddr;
  logic [MEM_ADDR_BITS-1:0] mem_waddr;
  logic [7:0]               mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  // address arithmetic
  logic [AddrW-1:0]     text_abs;
  logic [WideAddrW-1:0] text_wide;
  logic [WideAddrW-1:0] read_wide;
  logic [WideAddrW-1:0] mod_wide;
  assign text_abs  = cls_q + in_addr;
  assign text_wide = {5'd0, text_abs};
  assign read_wide = {5'd0, in_addr};
  assign mod_wide  = {5'd0, ma_q} + {23'd0, cnt_q};

  // modify arithmetic
  logic [AddrW-1:0] f20, r20;
  logic [23:0]      f24, r24, mod_res;
  assign f20 = {b_q[0][3:0], b_q[1], b_q[2]};
  assign f24 = {b_q[0], b_q[1], b_q[2]};
  assign r20 = sub_q ? (f20 - val_q) : (f20 + val_q);
  assign r24 = sub_q ? (f24 - {4'd0, val_q}) : (f24 + {4'd0, val_q});
  assign mod_res = hb5_q ? {b_q[0][7:4], r20} : r24;

  assign search_end = (CW'({1'b0, idx_q} + 1'b1) >= count_q);
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_HDR1: begin
              if (dsc_q >= DW'(MAX_SECTIONS)) begin
                state_d = S_DONE;
              end else if (count_q == '0) begin
                state_d = S_ENTER;
              end else begin
                state_d = S_SRCH_RD;
              end
            end
            OP_DEFINE: state_d = (count_q == '0) ? S_ENTER : S_SRCH_RD;
            OP_HDR2:   state_d = (lsi_q < dsc_q) ? S_SEC : S_DONE;
            OP_MODIFY: begin
              if (in_hb != HalfBytesShort && in_hb != HalfBytesLong) begin
                state_d = S_DONE;
              end else if (count_q == '0) begin
                state_d = S_MOD_RD;
              end else begin
                state_d = S_SRCH_RD;
              end
            end
            OP_READ:   state_d = S_SEC;
            OP_LOOKUP: state_d = (count_q == '0) ? S_DONE : S_SRCH_RD;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_SEC:     state_d = S_DONE;
      S_SRCH_RD: state_d = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (sym_rdata.name == name_q || search_end) begin
          case (op_q)
            OP_MODIFY: state_d = S_MOD_RD;
            OP_LOOKUP: state_d = S_DONE;
            default:   state_d = S_ENTER;
          endcase
        end else begin
          state_d = S_SRCH_RD;
        end
      end
      S_ENTER:  state_d = S_DONE;
      S_MOD_RD: state_d = (cnt_q == 2'd3) ? S_MOD_WR : S_MOD_RD;
      S_MOD_WR: state_d = (cnt_q == 2'd2) ? S_DONE : S_MOD_WR;
      S_DONE:   state_d = load_out ? S_IDLE : S_DONE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    count_d = count_q;
    dsc_d   = dsc_q;
    lsi_d   = lsi_q;
    nfa_d   = nfa_q;
    cds_d   = cds_q;
    cls_d   = cls_q;
    op_d    = op_q;
    name_d  = name_q;
    val_d   = val_q;
    ma_d    = ma_q;
    hb5_d   = hb5_q;
    sub_d   = sub_q;
    idx_d   = idx_q;
    found_d = found_q;
    cnt_d   = cnt_q;
    b_d     = b_q;
    res_d   = res_q;
    out_d   = out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    sym_we    = 1'b0;
    sym_waddr = idx_q;
    sym_wdata = '{name: name_q, value: val_q};
    sec_we    = 1'b0;
    sec_wdata = (dsc_q == '0) ? origin_q : nfa_q;
    mem_we    = 1'b0;
    mem_waddr = text_wide[MEM_ADDR_BITS-1:0];
    mem_wdata = in_data;
    mem_raddr = mod_wide[MEM_ADDR_BITS-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = in_op;
          name_d  = in_name;
          idx_d   = '0;
          found_d = 1'b0;
          cnt_d   = '0;
          hb5_d   = (in_hb == HalfBytesShort);
          sub_d   = in_sub;
          ma_d    = text_abs;
          res_d   = '0;
          case (in_op)
            OP_HDR1: begin
              if (dsc_q >= DW'(MAX_SECTIONS)) begin
                res_d.status = ST_FULL;
              end else begin
                sec_we = 1'b1;
                val_d  = sec_wdata;
                cds_d  = sec_wdata;
                nfa_d  = sec_wdata + in_len;
                dsc_d  = dsc_q + 1'b1;
              end
            end
            OP_DEFINE: val_d = cds_q + in_addr;
            OP_MODIFY: begin
              val_d = '0;
              if (in_hb != HalfBytesShort && in_hb != HalfBytesLong) begin
                res_d.status = ST_BAD_LEN;
              end
            end
            OP_TEXT: mem_we = 1'b1;
            OP_READ: mem_raddr = read_wide[MEM_ADDR_BITS-1:0];
            OP_LOOKUP: begin
              if (count_q == '0) begin
                res_d.status = ST_MISSING;
              end
            end
            default: ;
          endcase
        end
      end
      S_SEC: begin
        if (op_q == OP_HDR2) begin
          cls_d = sec_rdata_q;
          lsi_d = lsi_q + 1'b1;
        end else begin
          res_d.read_data = mem_rdata_q;
        end
      end
      S_SRCH_CMP: begin
        if (sym_rdata.name == name_q) begin
          found_d = 1'b1;
          if (op_q == OP_MODIFY || op_q == OP_LOOKUP) begin
            val_d = sym_rdata.value;
          end
        end else if (!search_end) begin
          idx_d = idx_q + 1'b1;
        end
        if (op_q == OP_LOOKUP) begin
          if (sym_rdata.name == name_q) begin
            res_d.found        = 1'b1;
            res_d.symbol_value = sym_rdata.value;
          end else if (search_end) begin
            res_d.status = ST_MISSING;
          end
        end
      end
      S_ENTER: begin
        if (found_q) begin
          sym_we = 1'b1;
        end else if (count_q >= CW'(SYMBOL_ENTRIES)) begin
          res_d.status = ST_FULL;
        end else begin
          sym_we    = 1'b1;
          sym_waddr = count_q[IW-1:0];
          count_d   = count_q + 1'b1;
        end
      end
      S_MOD_RD: begin
        if (cnt_q != 2'd0) begin
          b_d[cnt_q - 2'd1] = mem_rdata_q;
        end
        if (!found_q) begin
          res_d.status = ST_MISSING;
        end
        cnt_d = (cnt_q == 2'd3) ? 2'd0 : cnt_q + 2'd1;
      end
      S_MOD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = mod_wide[MEM_ADDR_BITS-1:0];
        case (cnt_q)
          2'd0:    mem_wdata = mod_res[23:16];
          2'd1:    mem_wdata = mod_res[15:8];
          default: mem_wdata = mod_res[7:0];
        endcase
        cnt_d = cnt_q + 2'd1;
      end
      S_DONE: begin
        if (load_out) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      origin_q    <= '0;
      count_q     <= '0;
      dsc_q       <= '0;
      lsi_q       <= '0;
      nfa_q       <= '0;
      cds_q       <= '0;
      cls_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        origin_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      dsc_q       <= dsc_d;
      lsi_q       <= lsi_d;
      nfa_q       <= nfa_d;
      cds_q       <= cds_d;
      cls_q       <= cls_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    name_q  <= name_d;
    val_q   <= val_d;
    ma_q    <= ma_d;
    hb5_q   <= hb5_d;
    sub_q   <= sub_d;
    idx_q   <= idx_d;
    found_q <= found_d;
    cnt_q   <= cnt_d;
    b_q     <= b_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q};

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the relocating linking loader: directed and random record streams.
`timescale 1ns / 1ps

module testbench;
  import rll_pkg::*;

  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned RandomItems = 1100;
  localparam int unsigned PoolSize    = 80;

  typedef struct {
    op_e         op;
    logic [47:0] name;
    logic [19:0] addr;
    logic [19:0] len;
    logic [7:0]  data;
    logic [3:0]  hb;
    logic        sub;
  } rec_t;

  typedef struct {
    logic [7:0]  rd;
    logic [19:0] sv;
    logic        fnd;
    status_e     st;
  } res_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [AddrW-1:0] cfg_wdata;
  logic s_valid, s_ready;
  logic [InDataW-1:0] s_data;
  logic m_valid, m_ready;
  logic [OutDataW-1:0] m_data;

  relocating_linking_loader DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // loader state mirror
  logic [19:0] origin;
  logic [47:0] sym_name [SymbolEntriesDef];
  logic [19:0] sym_val  [SymbolEntriesDef];
  int unsigned sym_cnt;
  logic [19:0] sec_start [MaxSectionsDef];
  int unsigned def_cnt, ld_idx;
  logic [19:0] next_free, cur_def, cur_ld;
  logic [7:0] mem [int];
  int written_q [$];

  res_t results_due [$];
  logic [47:0] name_pool [PoolSize];

  int errors, results_seen, items_sent, burst_left;
  int idle_cycles;
  bit hold_req;
  int rx_mode, rx_cnt, hold_cnt;

  function automatic bit find_sym(logic [47:0] nm, output int unsigned pos);
    pos = 0;
    for (int unsigned i = 0; i < sym_cnt; i++) begin
      if (sym_name[i] == nm) begin
        pos = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic status_e enter_sym(logic [47:0] nm, logic [19:0] v);
    int unsigned pos;
    if (find_sym(nm, pos)) begin
      sym_val[pos] = v;
      return ST_OK;
    end
    if (sym_cnt >= SymbolEntriesDef) return ST_FULL;
    sym_name[sym_cnt] = nm;
    sym_val[sym_cnt] = v;
    sym_cnt++;
    return ST_OK;
  endfunction

  function automatic void store_byte(logic [19:0] a, logic [7:0] d);
    if (!mem.exists(int'(a))) written_q = {written_q, int'(a)};
    mem[int'(a)] = d;
  endfunction

  function automatic res_t loader_predict(rec_t it);
    res_t r;
    logic [19:0] base, a, val, f20;
    logic [23:0] f24;
    logic [7:0] b0, b1, b2;
    int unsigned pos;
    r = '{rd: 8'h0, sv: 20'h0, fnd: 1'b0, st: ST_OK};
    case (it.op)
      OP_HDR1: begin
        if (def_cnt >= MaxSectionsDef) begin
          r.st = ST_FULL;
        end else begin
          base = (def_cnt == 0) ? origin : next_free;
          r.st = enter_sym(it.name, base);
          sec_start[def_cnt] = base;
          def_cnt++;
          cur_def = base;
          next_free = base + it.len;
        end
      end
      OP_DEFINE: r.st = enter_sym(it.name, cur_def + it.addr);
      OP_HDR2: begin
        if (ld_idx < def_cnt) begin
          cur_ld = sec_start[ld_idx];
          ld_idx++;
        end
      end
      OP_TEXT: store_byte(cur_ld + it.addr, it.data);
      OP_MODIFY: begin
        if (it.hb != HalfBytesShort && it.hb != HalfBytesLong) begin
          r.st = ST_BAD_LEN;
        end else begin
          a = cur_ld + it.addr;
          b0 = mem[int'(a)];
          b1 = mem[int'(20'(a + 20'd1))];
          b2 = mem[int'(20'(a + 20'd2))];
          val = 20'h0;
          if (find_sym(it.name, pos)) val = sym_val[pos];
          else r.st = ST_MISSING;
          if (it.hb == HalfBytesShort) begin
            f20 = {b0[3:0], b1, b2};
            f20 = it.sub ? f20 - val : f20 + val;
            f24 = {b0[7:4], f20};
          end else begin
            f24 = {b0, b1, b2};
            f24 = it.sub ? f24 - {4'h0, val} : f24 + {4'h0, val};
          end
          store_byte(a, f24[23:16]);
          store_byte(a + 20'd1, f24[15:8]);
          store_byte(a + 20'd2, f24[7:0]);
        end
      end
      OP_READ: r.rd = mem[int'(it.addr)];
      OP_LOOKUP: begin
        if (find_sym(it.name, pos)) begin
          r.sv = sym_val[pos];
          r.fnd = 1'b1;
        end else begin
          r.st = ST_MISSING;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic rec_t rand_rec();
    rec_t it;
    it.op = op_e'(3'($urandom_range(0, 7)));
    it.name = 48'({$urandom, $urandom});
    it.addr = 20'($urandom);
    it.len = 20'($urandom);
    it.data = 8'($urandom);
    it.hb = 4'($urandom);
    it.sub = 1'($urandom);
    return it;
  endfunction

  function automatic rec_t mk(op_e op, logic [47:0] nm, logic [19:0] addr, logic [19:0] len,
                              logic [7:0] data, logic [3:0] hb, logic sub);
    rec_t it;
    it = '{op: op, name: nm, addr: addr, len: len, data: data, hb: hb, sub: sub};
    return it;
  endfunction

  task automatic send_item(rec_t it);
    s_valid <= 1'b1;
    s_data <= {it.sub, it.hb, it.data, it.len, it.addr, it.name, it.op};
    do @(posedge clk); while (!s_ready);
    results_due = {results_due, loader_predict(it)};
    items_sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    burst_left = 0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_origin(logic [19:0] v);
    drain();
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    origin = v;
  endtask

  // result checker
  always @(posedge clk) begin
    res_t e, got;
    if (rst_n && m_valid && m_ready) begin
      got.rd = m_data[7:0];
      got.sv = m_data[27:8];
      got.fnd = m_data[28];
      got.st = status_e'(m_data[30:29]);
      results_seen++;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %h", m_data);
      end else begin
        e = results_due.pop_front();
        if (got.rd !== e.rd || got.sv !== e.sv || got.fnd !== e.fnd || got.st !== e.st
            || m_data[31] !== 1'b0) begin
          errors++;
          if (errors <= 10)
            $display({"ERROR: result %0d exp rd=%h sv=%h found=%b st=%0d",
                      " got rd=%h sv=%h found=%b st=%0d"},
                     results_seen, e.rd, e.sv, e.fnd, e.st, got.rd, got.sv, got.fnd, got.st);
        end
      end
    end
  end

  // receiver stall pattern and long hold-off
  always @(negedge clk) begin
    rx_cnt <= rx_cnt + 1;
    if (rx_cnt % 64 == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_req && hold_cnt == 0) hold_cnt <= 400;
    else if (hold_cnt > 1) hold_cnt <= hold_cnt - 1;
    else if (hold_cnt == 1) begin
      hold_cnt <= 0;
      hold_req <= 1'b0;
    end
    if (hold_cnt != 0 || hold_req) m_ready <= 1'b0;
    else case (rx_mode)
      0: m_ready <= 1'b1;
      1: m_ready <= 1'($urandom);
      2: m_ready <= ($urandom_range(0, 3) == 0);
      default: m_ready <= rx_cnt[2];
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_origin_register();
    write_origin(20'hFFFFF);
    write_origin(20'h00000);
    write_origin(20'h12345);
    write_origin(20'hFFFF0);
  endtask

  task automatic test_directed();
    logic [47:0] alpha, beta, proga, progb, nosym;
    alpha = 48'h414C50484100;
    beta  = 48'h424554410000;
    proga = 48'h50524F474100;
    progb = 48'h50524F474200;
    nosym = 48'hFFFFFFFFFFFF;
    name_pool[0] = alpha;
    name_pool[1] = beta;
    send_item(mk(OP_LOOKUP, alpha, 20'h0, 20'h0, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_HDR1, proga, 20'hFFFFF, 20'h00020, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_DEFINE, alpha, 20'h00005, 20'h0, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_DEFINE, alpha, 20'h00009, 20'h0, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_HDR1, progb, 20'h00000, 20'hFFFFF, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_DEFINE, beta, 20'hFFFFF, 20'h0, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_HDR2, proga, 20'h00000, 20'hFFFFF, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_TEXT, 48'h0, 20'h0000F, 20'h0, 8'hF5, 4'h0, 1'b0));
    send_item(mk(OP_TEXT, 48'h0, 20'h00010, 20'h0, 8'hFF, 4'h0, 1'b0));
    send_item(mk(OP_TEXT, 48'h0, 20'h00011, 20'h0, 8'hFE, 4'h0, 1'b0));
    send_item(mk(OP_MODIFY, alpha, 20'h0000F, 20'h0, 8'h00, HalfBytesShort, 1'b0));
    send_item(mk(OP_MODIFY, beta, 20'h0000F, 20'h0, 8'h00, HalfBytesLong, 1'b1));
    send_item(mk(OP_MODIFY, nosym, 20'h0000F, 20'h0, 8'h00, HalfBytesLong, 1'b0));
    send_item(mk(OP_MODIFY, alpha, 20'h0000F, 20'h0, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_MODIFY, alpha, 20'h0000F, 20'h0, 8'h00, 4'hF, 1'b1));
    send_item(mk(OP_READ, 48'h0, 20'hFFFFF, 20'h0, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_READ, 48'h0, 20'h00000, 20'h0, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_READ, 48'h0, 20'h00001, 20'h0, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_LOOKUP, alpha, 20'h0, 20'h0, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_LOOKUP, nosym, 20'h0, 20'h0, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_NONE, nosym, 20'hFFFFF, 20'hFFFFF, 8'hFF, 4'hF, 1'b1));
    send_item(mk(OP_HDR2, progb, 20'h0, 20'h00010, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_HDR2, progb, 20'h0, 20'h00010, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_TEXT, 48'h0, 20'h00000, 20'h0, 8'h00, 4'h0, 1'b0));
    send_item(mk(OP_READ, 48'h0, cur_ld, 20'h0, 8'h00, 4'h0, 1'b0));
  endtask

  task automatic send_random_record();
    rec_t it;
    int r;
    logic [19:0] base;
    it = rand_rec();
    it.name = name_pool[$urandom_range(0, PoolSize - 1)];
    r = $urandom_range(0, 99);
    if (r < 6) begin
      it.op = OP_HDR1;
      if ($urandom_range(0, 7) != 0) it.len = 20'($urandom_range(0, 300));
    end else if (r < 18) begin
      it.op = OP_DEFINE;
      if ($urandom_range(0, 3) != 0) it.addr = 20'($urandom_range(0, 511));
    end else if (r < 23) begin
      it.op = OP_HDR2;
    end else if (r < 45) begin
      it.op = OP_TEXT;
      if ($urandom_range(0, 3) != 0) it.addr = 20'($urandom_range(0, 511));
    end else if (r < 63) begin
      it.op = OP_MODIFY;
      if ($urandom_range(0, 1) == 0) begin
        base = 20'(written_q[$urandom_range(0, written_q.size() - 1)]);
        it.addr = base - cur_ld;
      end else begin
        it.addr = 20'($urandom_range(0, 511));
      end
      if ($urandom_range(0, 6) != 0) it.hb = $urandom_range(0, 1) ? HalfBytesLong
                                                                   : HalfBytesShort;
      for (int k = 0; k < 3; k++) begin
        if (!mem.exists(int'(20'(cur_ld + it.addr + 20'(k)))))
          send_item(mk(OP_TEXT, 48'h0, it.addr + 20'(k), 20'h0, 8'($urandom), 4'h0, 1'b0));
      end
    end else if (r < 80) begin
      it.op = OP_READ;
      it.addr = 20'(written_q[$urandom_range(0, written_q.size() - 1)]);
    end else if (r < 95) begin
      it.op = OP_LOOKUP;
    end else if (r < 97) begin
      it.op = OP_NONE;
    end else begin
      it.op = OP_LOOKUP;
      it.name = 48'({$urandom, $urandom});
    end
    send_item(it);
  endtask

  task automatic test_random();
    int stop_at;
    stop_at = items_sent + RandomItems;
    while (items_sent < stop_at) begin
      send_random_record();
      if ($urandom_range(0, 299) == 0) write_origin(20'($urandom));
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (40) send_random_record();
    drain();
    write_origin(20'h00000);
  endtask

  initial begin
    errors = 0; results_seen = 0; items_sent = 0; burst_left = 0; idle_cycles = 0;
    hold_req = 1'b0; rx_mode = 0; rx_cnt = 0; hold_cnt = 0;
    origin = 20'h0; sym_cnt = 0; def_cnt = 0; ld_idx = 0;
    next_free = 20'h0; cur_def = 20'h0; cur_ld = 20'h0;
    cfg_we = 1'b0; cfg_wdata = '0; s_valid = 1'b0; s_data = '0; m_ready = 1'b0;
    for (int i = 0; i < PoolSize; i++) name_pool[i] = 48'({$urandom, $urandom});
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_origin_register();
    test_directed();
    test_backpressure();
    test_random();
    drain();
    repeat (200) @(negedge clk);
    $display("Ran %0d records, checked %0d results, %0d symbols held, %0d sections defined",
             items_sent, results_seen, sym_cnt, def_cnt);
    $display("Covered wrap, overwrite, table full, missing symbol, bad length and stalls");
    if (errors == 0 && results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: relocating_linking_loader.f
sv/rll_pkg.sv
sv/rll_sym_ram.sv
sv/relocating_linking_loader.sv
test/testbench.sv
